>>> rtl/lru_writeback_block_cache_assert.svh
// Assertion macros shared by the checker of the block cache controller.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef LRU_WRITEBACK_BLOCK_CACHE_ASSERT_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_ASSERT_SVH
// Implication in the same cycle, checked out of reset.
`define LRUBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache controller assertion failed");
// Implication in the next cycle, checked out of reset.
`define LRUBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache controller assertion failed");
`endif

>>> rtl/lrubc_pkg.sv
// Package of the block cache controller: codes, entry type and cell ops.
// Depends on nothing.
`default_nettype none
package lrubc_pkg;
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_WB    = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [1:0] REG_BLOCK_BYTES    = 2'd0;
  localparam logic [1:0] REG_STORAGE_LENGTH = 2'd1;
  localparam logic [1:0] REG_LENGTH_KNOWN   = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [31:0] tag;
    logic [16:0] len;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PREV = 2'd1,
    OP_NEXT = 2'd2
  } cell_op_t;
endpackage
`default_nettype wire

>>> rtl/lrubc_if.sv
// Handshake interfaces of the block cache controller: access items in,
// result items out. Depends on nothing.
`default_nettype none
interface lrubc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] block_number;
  modport source (output valid, cmd, block_number, input ready);
  modport sink (input valid, cmd, block_number, output ready);
endinterface

interface lrubc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [31:0] target_block;
  logic [16:0] byte_length;
  logic        last;
  modport source (output valid, kind, slot, target_block, byte_length, last, input ready);
  modport sink (input valid, kind, slot, target_block, byte_length, last, output ready);
endinterface
`default_nettype wire

>>> rtl/lru_writeback_block_cache.sv
// Top level of the fully associative LRU write-back block cache controller.
// Depends on lrubc_pkg, lrubc_if and lrubc_cell.
`default_nettype none
// Usage: access items (read, write, flush) enter on in_if; each causes one or
// more result items on out_if, the final one flagged by last. Registers are
// written over the APB port (8-byte stride); the user must write them only
// while the block is idle, which the block does not enforce. The state lives
// in a chain of WAYS cells, cell 0 holding the most recently used slot. S_IDLE
// accepts a read or write, S_LOOK registers the tag compare across all cells
// and the offset multiply, S_WB writes back a dirty victim if any, and S_FIN
// updates the chain. A flush rotates the chain once around, one cell per cycle
// unless a dirty cell waits on a stalled output. A command code of 3 is
// accepted and dropped. Results wait in an output register; while the receiver
// stalls, the block still takes the next item and runs it up to its first
// result, then holds; a flush keeps rotating past clean cells. Reset
// (synchronous, rst_n low) empties every slot, clears all dirty marks and puts
// slot i at recency position i; registers return to their defaults.
module lru_writeback_block_cache
  import lrubc_pkg::*;
#(
  parameter int WAYS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lrubc_in_if.sink         in_if,
  lrubc_out_if.source      out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  localparam int SW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_WB    = 6'b000100,
    S_FIN   = 6'b001000,
    S_FLUSH = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [16:0] block_bytes_r;
  logic [39:0] storage_length_r;
  logic        length_known_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bytes_r    <= 17'd512;
      storage_length_r <= 40'd0;
      length_known_r   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_BLOCK_BYTES:    block_bytes_r    <= pwdata[16:0];
        REG_STORAGE_LENGTH: storage_length_r <= pwdata[39:0];
        REG_LENGTH_KNOWN:   length_known_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_BLOCK_BYTES:    prdata = {47'd0, block_bytes_r};
      REG_STORAGE_LENGTH: prdata = {24'd0, storage_length_r};
      REG_LENGTH_KNOWN:   prdata = {63'd0, length_known_r};
      default:            prdata = 64'd0;
    endcase
  end

  // Current item.
  logic [1:0]      cmd_r;
  logic [31:0]     blk_r;
  logic [WAYS-1:0] hit_r;
  logic [48:0]     prod_r;
  logic [CW-1:0]   cnt_r;
  logic            any_r;

  // Chain of cells.
  entry_t          ent   [WAYS];
  logic [SW-1:0]   slots [WAYS];
  entry_t          prev_e[WAYS];
  logic [SW-1:0]   prev_s[WAYS];
  entry_t          next_e[WAYS];
  logic [SW-1:0]   next_s[WAYS];
  cell_op_t        ops   [WAYS];
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] dv;
  logic [WAYS-1:0] dv_rest;
  logic [WAYS-1:0] at_or_above;

  entry_t          head_e;
  logic [SW-1:0]   head_s;
  entry_t          hit_e;
  logic [SW-1:0]   hit_s;
  entry_t          head0_clean;

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    lrubc_cell #(.SW(SW), .INIT_SLOT(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (ops[i]),
      .prev_ent (prev_e[i]),
      .prev_slot(prev_s[i]),
      .next_ent (next_e[i]),
      .next_slot(next_s[i]),
      .key      (blk_r),
      .ent      (ent[i]),
      .slot     (slots[i]),
      .match    (match[i])
    );
    assign dv[i] = ent[i].valid && ent[i].dirty;
  end

  // The cell after the last one is the head cell with its dirty mark cleared,
  // so one full rotation cleans every entry and restores the order.
  always_comb begin
    head0_clean       = ent[0];
    head0_clean.dirty = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      prev_e[i] = (i == 0) ? head_e : ent[(i == 0) ? 0 : i - 1];
      prev_s[i] = (i == 0) ? head_s : slots[(i == 0) ? 0 : i - 1];
      next_e[i] = (i == WAYS - 1) ? head0_clean : ent[(i == WAYS - 1) ? 0 : i + 1];
      next_s[i] = (i == WAYS - 1) ? slots[0] : slots[(i == WAYS - 1) ? 0 : i + 1];
    end
  end

  always_comb begin
    dv_rest    = dv;
    dv_rest[0] = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      at_or_above[i] = |(hit_r >> i);
    end
  end

  // One-hot select of the hit entry.
  always_comb begin
    hit_e = '0;
    hit_s = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (hit_r[i]) begin
        hit_e = hit_e | ent[i];
        hit_s = hit_s | slots[i];
      end
    end
  end

  // Fill length from the registered block offset.
  logic [48:0] stor49;
  logic [48:0] remain;
  logic [16:0] fill_len;

  always_comb begin
    stor49 = {9'd0, storage_length_r};
    remain = stor49 - prod_r;
    if (!length_known_r) begin
      fill_len = block_bytes_r;
    end else if (stor49 <= prod_r) begin
      fill_len = 17'd0;
    end else if (remain < {32'd0, block_bytes_r}) begin
      fill_len = remain[16:0];
    end else begin
      fill_len = block_bytes_r;
    end
  end

  logic hit_any;
  assign hit_any = |hit_r;

  always_comb begin
    if (hit_any) begin
      head_e       = hit_e;
      head_e.dirty = hit_e.dirty || (cmd_r == CMD_WRITE);
      head_s       = hit_s;
    end else begin
      head_e = '{valid: 1'b1, dirty: (cmd_r == CMD_WRITE), tag: blk_r, len: fill_len};
      head_s = slots[WAYS-1];
    end
  end

  // Output register.
  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [3:0]  oslot_r;
  logic [31:0] otag_r;
  logic [16:0] olen_r;
  logic        olast_r;
  logic        out_free;
  logic        emit;
  logic [1:0]  e_kind;
  logic [SW-1:0] e_slot;
  logic [SW+3:0] e_slot_ext;
  logic [31:0] e_tag;
  logic [16:0] e_len;
  logic        e_last;
  logic        chain_shift;
  logic        chain_rot;

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    emit        = 1'b0;
    e_kind      = KIND_HIT;
    e_slot      = '0;
    e_tag       = '0;
    e_len       = '0;
    e_last      = 1'b0;
    chain_shift = 1'b0;
    chain_rot   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.cmd == CMD_FLUSH) begin
            state_nxt = S_FLUSH;
          end else if (in_if.cmd != CMD_NONE) begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_nxt = (!(|match) && dv[WAYS-1]) ? S_WB : S_FIN;
      end
      S_WB: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_WB;
          e_slot    = slots[WAYS-1];
          e_tag     = ent[WAYS-1].tag;
          e_len     = ent[WAYS-1].len;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit        = 1'b1;
          chain_shift = 1'b1;
          e_kind      = hit_any ? KIND_HIT : KIND_FILL;
          e_slot      = head_s;
          e_tag       = blk_r;
          e_len       = hit_any ? 17'd0 : fill_len;
          e_last      = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (cnt_r == CW'(WAYS)) begin
          state_nxt = any_r ? S_IDLE : S_EMPTY;
        end else if (!dv[0]) begin
          chain_rot = 1'b1;
        end else if (out_free) begin
          chain_rot = 1'b1;
          emit      = 1'b1;
          e_kind    = KIND_WB;
          e_slot    = slots[0];
          e_tag     = ent[0].tag;
          e_len     = ent[0].len;
          e_last    = !(|dv_rest);
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = KIND_EMPTY;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign e_slot_ext = {4'd0, e_slot};

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (chain_rot) begin
        ops[i] = OP_NEXT;
      end else if (chain_shift && (!hit_any || at_or_above[i])) begin
        ops[i] = OP_PREV;
      end else begin
        ops[i] = OP_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      any_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        cnt_r <= '0;
        any_r <= 1'b0;
      end else if (chain_rot) begin
        cnt_r <= cnt_r + CW'(1);
        if (emit) begin
          any_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_if.valid) begin
      cmd_r <= in_if.cmd;
      blk_r <= in_if.block_number;
    end
    if (state_r == S_LOOK) begin
      hit_r  <= match;
      prod_r <= {17'd0, blk_r} * {32'd0, block_bytes_r};
    end
    if (emit) begin
      kind_r  <= e_kind;
      oslot_r <= e_slot_ext[3:0];
      otag_r  <= e_tag;
      olen_r  <= e_len;
      olast_r <= e_last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.slot         = oslot_r;
  assign out_if.target_block = otag_r;
  assign out_if.byte_length  = olen_r;
  assign out_if.last         = olast_r;
endmodule
`default_nettype wire

>>> rtl/lrubc_cell.sv
// One recency position of the LRU chain: holds a slot id and its entry.
// Depends on lrubc_pkg.
`default_nettype none
module lrubc_cell
  import lrubc_pkg::*;
#(
  parameter int SW = 4,
  parameter int INIT_SLOT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cell_op_t      op,
  input  wire entry_t        prev_ent,
  input  wire logic [SW-1:0] prev_slot,
  input  wire entry_t        next_ent,
  input  wire logic [SW-1:0] next_slot,
  input  wire logic [31:0]   key,
  output entry_t             ent,
  output logic [SW-1:0]      slot,
  output logic               match
);
  logic          valid_r, dirty_r;
  logic [31:0]   tag_r;
  logic [16:0]   len_r;
  logic [SW-1:0] slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      slot_r  <= SW'(INIT_SLOT);
    end else begin
      case (op)
        OP_PREV: begin
          valid_r <= prev_ent.valid;
          dirty_r <= prev_ent.dirty;
          slot_r  <= prev_slot;
        end
        OP_NEXT: begin
          valid_r <= next_ent.valid;
          dirty_r <= next_ent.dirty;
          slot_r  <= next_slot;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_PREV: begin
        tag_r <= prev_ent.tag;
        len_r <= prev_ent.len;
      end
      OP_NEXT: begin
        tag_r <= next_ent.tag;
        len_r <= next_ent.len;
      end
      default: ;
    endcase
  end

  assign ent   = '{valid: valid_r, dirty: dirty_r, tag: tag_r, len: len_r};
  assign slot  = slot_r;
  assign match = valid_r && (tag_r == key);
endmodule
`default_nettype wire

>>> rtl/lrubc_chk.sv
// Port-level checker of the block cache controller and its bind statement.
// Depends on lrubc_pkg, lru_writeback_block_cache_assert.svh and the top level.
`default_nettype none
`include "lru_writeback_block_cache_assert.svh"
module lrubc_chk
  import lrubc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [3:0]  slot,
  input wire logic [31:0] target_block,
  input wire logic [16:0] byte_length,
  input wire logic        last,
  input wire logic        pready
);
  // An empty flush result carries nothing and ends its item.
  `LRUBC_ASSERT_SAME(a_empty_flush, out_valid && kind == KIND_EMPTY, last && slot == 4'd0 && target_block == 32'd0 && byte_length == 17'd0)
  // A hit moves no data and is the only result of its item.
  `LRUBC_ASSERT_SAME(a_hit_alone, out_valid && kind == KIND_HIT, last && byte_length == 17'd0)
  // A fill always closes its item.
  `LRUBC_ASSERT_SAME(a_fill_last, out_valid && kind == KIND_FILL, last)
  // A stalled result holds.
  `LRUBC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(slot) && $stable(target_block) && $stable(byte_length) && $stable(last))
  // The register port never inserts wait states.
  `LRUBC_ASSERT_SAME(a_pready, 1'b1, pready)
endmodule

bind lru_writeback_block_cache lrubc_chk u_lrubc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .kind        (out_if.kind),
  .slot        (out_if.slot),
  .target_block(out_if.target_block),
  .byte_length (out_if.byte_length),
  .last        (out_if.last),
  .pready      (pready)
);
`default_nettype wire
